// ----- hdl/hcbd_pkg.sv -----
// Shared types, codes and a helper function for the chunked body decoder.
`default_nettype none

package hcbd_pkg;

  // Default width of the chunk length register
  localparam int unsigned LEN_BITS_DEF = 32;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned ERR_W  = 2;

  // Framing characters
  localparam logic [BYTE_W-1:0] CH_CR = 8'h0D;
  localparam logic [BYTE_W-1:0] CH_LF = 8'h0A;

  // Error codes as reported on the result channel
  localparam logic [ERR_W-1:0] ERR_NONE  = 2'd0;
  localparam logic [ERR_W-1:0] ERR_FRAME = 2'd1;
  localparam logic [ERR_W-1:0] ERR_OVF   = 2'd2;

  // Decoder phase
  typedef enum logic [2:0] {
    PH_SIZE      = 3'd0,
    PH_SIZE_LF   = 3'd1,
    PH_DATA      = 3'd2,
    PH_DATA_CR   = 3'd3,
    PH_DATA_LF   = 3'd4,
    PH_DONE      = 3'd5,
    PH_ERR_FRAME = 3'd6,
    PH_ERR_OVF   = 3'd7
  } phase_e;

  // Hex digit decode: bit 4 set means the byte is a valid hex digit
  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } hex_t;

  function automatic hex_t hex_decode(input logic [BYTE_W-1:0] c);
    hex_t h;
    logic [BYTE_W-1:0] diff;
    h    = '{ok: 1'b0, val: 4'd0};
    diff = '0;
    if (c >= 8'h30 && c <= 8'h39) begin
      diff = c - 8'h30;
      h    = '{ok: 1'b1, val: diff[3:0]};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      diff = c - 8'h57;
      h    = '{ok: 1'b1, val: diff[3:0]};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      diff = c - 8'h37;
      h    = '{ok: 1'b1, val: diff[3:0]};
    end
    return h;
  endfunction

endpackage

`default_nettype wire

// ----- hdl/hcbd_in_if.sv -----
// Input channel interface: raw chunked-stream bytes with a restart flag.
`default_nettype none

interface hcbd_in_if;
  import hcbd_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] in_byte;
  logic              begin_req;

  modport source (output valid, output in_byte, output begin_req, input ready);
  modport sink   (input valid, input in_byte, input begin_req, output ready);
endinterface

`default_nettype wire

// ----- hdl/hcbd_out_if.sv -----
// Output channel interface: decoded body byte with done and error status.
`default_nettype none

interface hcbd_out_if;
  import hcbd_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] body_byte;
  logic              body_valid;
  logic              body_done;
  logic [ERR_W-1:0]  error_code;

  modport source (output valid, output body_byte, output body_valid, output body_done,
                  output error_code, input ready);
  modport sink   (input valid, input body_byte, input body_valid, input body_done,
                  input error_code, output ready);
endinterface

`default_nettype wire

// ----- hdl/http_chunked_body_decoder.sv -----
// Top level: HTTP chunked transfer body decoder, one byte per transaction.
// Each byte's result is loaded into the output register as the byte is taken.
// One byte per cycle while out_o.ready is high; the output register refills as it drains.
// Each byte updates the phase; size digits shift-add and payload bytes decrement the length.
// Reset (rst_ni low, asynchronous): phase to size digits, length and last-chunk flag
// cleared, output register emptied.
`default_nettype none

module http_chunked_body_decoder #(
  parameter int unsigned LEN_BITS = hcbd_pkg::LEN_BITS_DEF
) (
  input  wire           clk_i,
  input  wire           rst_ni,
  hcbd_in_if.sink       in_i,
  hcbd_out_if.source    out_o
);
  import hcbd_pkg::*;

  // Decoder state
  phase_e              phase_q, phase_d;
  logic [LEN_BITS-1:0] remaining_q, remaining_d;
  logic                last_chunk_q, last_chunk_d;

  // Output register
  logic              out_valid_q;
  logic [BYTE_W-1:0] body_byte_q, body_byte_d;
  logic              body_valid_q, body_valid_d;
  logic              body_done_q, body_done_d;
  logic [ERR_W-1:0]  error_code_q, error_code_d;

  logic   in_fire;
  phase_e phase_cur;
  logic [LEN_BITS-1:0] remaining_cur;
  logic                last_chunk_cur;
  logic [LEN_BITS-1:0] remaining_dec;
  hex_t                hex;

  // Take a new byte whenever the output register is empty or drains this cycle
  assign in_i.ready = !out_valid_q || out_o.ready;
  assign in_fire    = in_i.valid && in_i.ready;

  assign hex           = hex_decode(in_i.in_byte);
  assign remaining_dec = remaining_cur - LEN_BITS'(1);

  // Decode one byte against the (possibly restarted) state
  always_comb begin
    if (in_i.begin_req) begin
      phase_cur      = PH_SIZE;
      remaining_cur  = '0;
      last_chunk_cur = 1'b0;
    end else begin
      phase_cur      = phase_q;
      remaining_cur  = remaining_q;
      last_chunk_cur = last_chunk_q;
    end

    phase_d      = phase_cur;
    remaining_d  = remaining_cur;
    last_chunk_d = last_chunk_cur;
    body_byte_d  = '0;
    body_valid_d = 1'b0;
    body_done_d  = 1'b0;

    case (phase_cur)
      PH_SIZE: begin
        if (hex.ok) begin
          if (remaining_cur[LEN_BITS-1 -: 4] != 4'd0) begin
            phase_d = PH_ERR_OVF;
          end else begin
            remaining_d = {remaining_cur[LEN_BITS-5:0], hex.val};
          end
        end else if (in_i.in_byte == CH_CR) begin
          phase_d = PH_SIZE_LF;
        end else begin
          phase_d = PH_ERR_FRAME;
        end
      end
      PH_SIZE_LF: begin
        if (in_i.in_byte != CH_LF) begin
          phase_d = PH_ERR_FRAME;
        end else if (remaining_cur == '0) begin
          last_chunk_d = 1'b1;
          phase_d      = PH_DATA_CR;
        end else begin
          phase_d = PH_DATA;
        end
      end
      PH_DATA: begin
        body_byte_d  = in_i.in_byte;
        body_valid_d = 1'b1;
        remaining_d  = remaining_dec;
        if (remaining_dec == '0) begin
          phase_d = PH_DATA_CR;
        end
      end
      PH_DATA_CR: begin
        phase_d = (in_i.in_byte == CH_CR) ? PH_DATA_LF : PH_ERR_FRAME;
      end
      PH_DATA_LF: begin
        if (in_i.in_byte != CH_LF) begin
          phase_d = PH_ERR_FRAME;
        end else if (last_chunk_cur) begin
          body_done_d = 1'b1;
          phase_d     = PH_DONE;
        end else begin
          remaining_d = '0;
          phase_d     = PH_SIZE;
        end
      end
      default: begin
        // hold done and error phases until a restart
      end
    endcase

    case (phase_d)
      PH_ERR_FRAME: error_code_d = ERR_FRAME;
      PH_ERR_OVF:   error_code_d = ERR_OVF;
      default:      error_code_d = ERR_NONE;
    endcase
  end

  // Advance decoder state on each accepted transaction
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_SIZE;
      remaining_q  <= '0;
      last_chunk_q <= 1'b0;
    end else if (in_fire) begin
      phase_q      <= phase_d;
      remaining_q  <= remaining_d;
      last_chunk_q <= last_chunk_d;
    end
  end

  // Track output register occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_fire) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  // Load result payload
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      body_byte_q  <= body_byte_d;
      body_valid_q <= body_valid_d;
      body_done_q  <= body_done_d;
      error_code_q <= error_code_d;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.body_byte  = body_byte_q;
  assign out_o.body_valid = body_valid_q;
  assign out_o.body_done  = body_done_q;
  assign out_o.error_code = error_code_q;

  // A payload byte never carries done or an error
  a_body_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && body_valid_q |-> !body_done_q && error_code_q == ERR_NONE)
    else $error("payload byte flagged done or error");

  // While in payload phase some bytes are still owed
  a_data_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_DATA |-> remaining_q != '0)
    else $error("payload phase with zero bytes remaining");

  // The zero-size chunk never enters payload phase
  a_last_no_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    last_chunk_q |-> phase_q != PH_DATA)
    else $error("last chunk in payload phase");

  // A held overflow keeps reporting overflow
  a_ovf_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && !in_i.begin_req && phase_q == PH_ERR_OVF |=>
      out_valid_q && error_code_q == ERR_OVF && phase_q == PH_ERR_OVF)
    else $error("held overflow lost");

  // Done is reported only when leaving the final LF
  a_done_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && body_done_d |=> phase_q == PH_DONE)
    else $error("done without done phase");

endmodule

`default_nettype wire
